### hdl/radix52_middle_product_unit_defines.svh
// ----------------------------------------------------------------------------
// Radix-2^52 middle product unit: assertion macros
// Shared property forms for the port checker; clk and rst come from the
// module that uses them.
// ----------------------------------------------------------------------------
`ifndef RADIX52_MIDDLE_PRODUCT_UNIT_DEFINES_SVH
`define RADIX52_MIDDLE_PRODUCT_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define R52MP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define R52MP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/r52mp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r52mp_pkg
// Widths, word layout, op codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package r52mp_pkg;

  localparam int LIMB_W  = 52;
  localparam int HALF_W  = 26;
  localparam int DIGIT_W = 57;
  localparam int IDX_W   = 4;
  localparam int S_DATA_W = 56;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 64;

  // input word layout, lowest bit first
  localparam int IDX_LSB    = 0;
  localparam int LIMB_LSB   = 4;

  // input tuser layout
  localparam int OP_BIT     = 0;
  localparam int FIRST_BIT  = 1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef struct packed {
    logic coeff_we;
    logic push;
    logic issue;
    logic last;
    logic load_out;
  } r52mp_cmd_t;

  typedef struct packed {
    logic fire;   // this push completes a digit window
    logic done;   // last tap has been accumulated
  } r52mp_status_t;

endpackage

### hdl/r52mp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r52mp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module r52mp_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/r52mp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r52mp_ctrl
// Sequencer: takes input words, walks the taps, hands the digit to the
// output register.
// ----------------------------------------------------------------------------
module r52mp_ctrl import r52mp_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    op,
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output r52mp_cmd_t              cmd,
  output logic [$clog2(TAPS)-1:0] tap,
  input  r52mp_status_t           status
);

  localparam int AW = $clog2(TAPS);

  typedef enum logic [1:0] {IDLE, RUN, DRAIN, HOLD} state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd.coeff_we = accept && (op == OP_LOAD);
    cmd.push     = accept && (op == OP_PUSH);
    cmd.issue    = (state == RUN);
    cmd.last     = (tap == AW'(TAPS - 1));
    cmd.load_out = (state == HOLD) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      tap      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (status.fire) begin
            tap   <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          tap <= tap + AW'(1);
          if (cmd.last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (status.done) begin
            state <= HOLD;
          end
        end
        HOLD: begin
          // previous word may still sit in the output register
          if (cmd.load_out) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/r52mp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r52mp_datapath
// Coefficient RAM, limb window, four-stage split multiplier pipeline and
// the digit accumulator.
// ----------------------------------------------------------------------------
module r52mp_datapath import r52mp_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  r52mp_cmd_t              cmd,
  input  logic [$clog2(TAPS)-1:0] tap,
  input  logic [IDX_W-1:0]        coeff_index,
  input  logic [LIMB_W-1:0]       limb_value,
  input  logic                    first,
  output r52mp_status_t           status,
  output logic [DIGIT_W-1:0]      raw_digit
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);
  localparam int IW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // coefficient store
  logic [IW-1:0]     idx_ext;
  logic              idx_ok;
  logic [TAPS-1:0]   cvalid;
  logic [LIMB_W-1:0] rdata;

  // limb window and its working copy
  logic [LIMB_W-1:0] win     [TAPS+1];
  logic [LIMB_W-1:0] win_next[TAPS+1];
  logic [LIMB_W-1:0] wk      [TAPS+1];
  logic [CW-1:0]     fill;
  logic [CW-1:0]     fill_next;
  logic              fire;

  // pipeline
  logic              v1, v2, v3, v4, l1, l2, l3, l4, done;
  logic              bv1;
  logic [LIMB_W-1:0] a0_1, a1_1, b;
  logic [LIMB_W-1:0] ap00, ap01, ap10, bp00, bp01, bp10, bp11;
  logic [HALF_W-1:0] amid3;
  logic [LIMB_W:0]   bmid3;
  logic [LIMB_W-1:0] ap00_3, bp00_3, bp11_3;
  logic [LIMB_W-1:0] a_lo4, b_hi4;
  logic [LIMB_W:0]   b_low_sum;
  logic [DIGIT_W-1:0] acc;

  // 26x26 partial product
  function automatic logic [LIMB_W-1:0] pmul(input logic [HALF_W-1:0] x,
                                             input logic [HALF_W-1:0] y);
    return LIMB_W'(x) * LIMB_W'(y);
  endfunction

  assign idx_ext = IW'(coeff_index);
  assign idx_ok  = idx_ext < IW'(TAPS);

  r52mp_ram #(.WIDTH(LIMB_W), .DEPTH(TAPS)) u_coeff_ram (
    .clk   (clk),
    .we    (cmd.coeff_we && idx_ok),
    .waddr (idx_ext[AW-1:0]),
    .wdata (limb_value),
    .raddr (tap),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cvalid <= '0;
    end else if (cmd.coeff_we && idx_ok) begin
      cvalid[idx_ext[AW-1:0]] <= 1'b1;
    end
  end

  // window after this push; 'first' drops older limbs
  always_comb begin
    win_next[0] = limb_value;
    for (int d = 1; d <= TAPS; d++) begin
      win_next[d] = first ? '0 : win[d-1];
    end
    if (first) begin
      fill_next = CW'(1);
    end else if (fill == CW'(TAPS)) begin
      fill_next = fill;
    end else begin
      fill_next = fill + CW'(1);
    end
  end

  assign fire        = cmd.push && (fill_next == CW'(TAPS));
  assign status.fire = fire;
  assign status.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int d = 0; d <= TAPS; d++) begin
        win[d] <= '0;
      end
    end else if (cmd.push) begin
      fill <= fill_next;
      for (int d = 0; d <= TAPS; d++) begin
        win[d] <= win_next[d];
      end
    end
  end

  // working copy slides one tap per issue so taps are read at fixed places
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int d = 0; d <= TAPS; d++) begin
        wk[d] <= win_next[d];
      end
    end else if (cmd.issue) begin
      for (int d = 0; d < TAPS; d++) begin
        wk[d] <= wk[d+1];
      end
      wk[TAPS] <= '0;
    end
  end

  assign b = bv1 ? rdata : '0;

  // B products form hi52 of a[p-1-t]*b[t]; A products only need lo52
  assign b_low_sum = {1'b0, bp00_3} + {1'b0, bmid3[HALF_W-1:0], {HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    a0_1   <= wk[0];
    a1_1   <= wk[1];
    bv1    <= cvalid[tap];

    ap00   <= pmul(a0_1[HALF_W-1:0],      b[HALF_W-1:0]);
    ap01   <= pmul(a0_1[HALF_W-1:0],      b[LIMB_W-1:HALF_W]);
    ap10   <= pmul(a0_1[LIMB_W-1:HALF_W], b[HALF_W-1:0]);
    bp00   <= pmul(a1_1[HALF_W-1:0],      b[HALF_W-1:0]);
    bp01   <= pmul(a1_1[HALF_W-1:0],      b[LIMB_W-1:HALF_W]);
    bp10   <= pmul(a1_1[LIMB_W-1:HALF_W], b[HALF_W-1:0]);
    bp11   <= pmul(a1_1[LIMB_W-1:HALF_W], b[LIMB_W-1:HALF_W]);

    amid3  <= ap01[HALF_W-1:0] + ap10[HALF_W-1:0];
    ap00_3 <= ap00;
    bmid3  <= {1'b0, bp01} + {1'b0, bp10};
    bp00_3 <= bp00;
    bp11_3 <= bp11;

    a_lo4  <= ap00_3 + {amid3, {HALF_W{1'b0}}};
    b_hi4  <= bp11_3 + LIMB_W'(bmid3[LIMB_W:HALF_W]) + LIMB_W'(b_low_sum[LIMB_W]);

    if (fire) begin
      acc <= '0;
    end else if (v4) begin
      acc <= acc + DIGIT_W'(a_lo4) + DIGIT_W'(b_hi4);
    end

    if (cmd.load_out) begin
      raw_digit <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4} <= '0;
      {l1, l2, l3, l4} <= '0;
      done             <= 1'b0;
    end else begin
      v1   <= cmd.issue;
      l1   <= cmd.issue && cmd.last;
      v2   <= v1;
      l2   <= l1;
      v3   <= v2;
      l3   <= l2;
      v4   <= v3;
      l4   <= l3;
      done <= v4 && l4;
    end
  end

endmodule

### hdl/radix52_middle_product_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix52_middle_product_unit
// Middle product digits of radix-2^52 big integers, one tap per cycle.
// ----------------------------------------------------------------------------
// A coefficient load, and a push that does not yet complete TAPS limbs of the
// vector, leave the sequencer in IDLE. A push that yields a digit takes it
// through RUN, DRAIN and HOLD; the digit is offered as HOLD ends, and the
// next word can be taken in IDLE again. In RUN one tap per cycle goes
// through a coefficient RAM read and a four-stage split 52x52 multiplier pair
// whose low and high halves are summed into a 57-bit accumulator. The input is
// not ready while a digit is computed, nor while a finished digit waits for
// the previous one to leave the output register; a digit waiting on the output
// does not block new loads or short pushes.
module radix52_middle_product_unit import r52mp_pkg::*; #(
  parameter int TAPS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,  // coeff_index[3:0], limb_value[51:0]
  input  logic [S_USER_W-1:0] s_tuser,  // op, first
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata   // raw_digit[56:0], pad
);

  r52mp_cmd_t              cmd;
  r52mp_status_t           status;
  logic [$clog2(TAPS)-1:0] tap;
  logic [DIGIT_W-1:0]      raw_digit;

  r52mp_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .op       (s_tuser[OP_BIT]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .tap      (tap),
    .status   (status)
  );

  r52mp_datapath #(.TAPS(TAPS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .tap         (tap),
    .coeff_index (s_tdata[IDX_LSB +: IDX_W]),
    .limb_value  (s_tdata[LIMB_LSB +: LIMB_W]),
    .first       (s_tuser[FIRST_BIT]),
    .status      (status),
    .raw_digit   (raw_digit)
  );

  assign m_tdata = M_DATA_W'(raw_digit);

endmodule

### hdl/r52mp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r52mp_checker
// Port-level checks on the middle product unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix52_middle_product_unit_defines.svh"

module r52mp_checker import r52mp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_USER_W-1:0] s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  logic s_acc;
  logic s_load;
  logic s_restart;
  logic out_stall;

  assign s_acc     = s_tvalid && s_tready;
  assign s_load    = s_acc && (s_tuser[OP_BIT] == OP_LOAD);
  assign s_restart = s_acc && (s_tuser[OP_BIT] == OP_PUSH) && s_tuser[FIRST_BIT];
  assign out_stall = m_tvalid && !m_tready;

  `R52MP_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "output word moved")
  `R52MP_ASSERT_NEXT(a_load_one_cycle, s_load, s_tready, "load took more than one cycle")
  `R52MP_ASSERT_NEXT(a_first_no_digit, s_restart, s_tready, "first push started a digit")
  `R52MP_ASSERT_SAME(a_digit_after_busy, $rose(m_tvalid), $past(!s_tready), "digit not busy")

endmodule

bind radix52_middle_product_unit r52mp_checker u_r52mp_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for radix52_middle_product_unit. A short directed table
// covers the reset state, limb extremes and vector restarts. Random coefficient
// loads and multiplicand vectors follow under four idle/stall phases. Each
// accepted word runs through a local model of the coefficient store and limb
// window; its digits (or a row's own digit) are compared in order with the output.
// ----------------------------------------------------------------------------
module testbench import r52mp_pkg::*;;

  localparam int TAPS           = 16;
  localparam int DIR_ROWS       = 23;
  localparam int ITEMS_PER_PHASE = 357;
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [LIMB_W-1:0] LIMB_MAX = {LIMB_W{1'b1}};

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  idx;
    logic [LIMB_W-1:0] limb;
    logic              first;
    bit                has_exp;
    logic [DIGIT_W-1:0] exp_digit;
  } stim_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // typed expectation riding along with the word on s_tdata
  bit                 cur_has_exp = 1'b0;
  logic [DIGIT_W-1:0] cur_exp = '0;

  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  mismatches = 0;
  int  words_sent = 0;

  // model state
  logic [LIMB_W-1:0]  coeffs [TAPS];
  logic [LIMB_W-1:0]  window [TAPS+1];
  int                 depth;
  logic [DIGIT_W-1:0] digits_due [$];

  stim_row_t dir_rows [DIR_ROWS];

  radix52_middle_product_unit #(.TAPS(TAPS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [DIGIT_W-1:0] got,
                                 input logic [DIGIT_W-1:0] want);
    $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one accepted word to the model; returns the digit a full window yields.
  task automatic take_word(input logic [S_DATA_W-1:0] w, input logic [S_USER_W-1:0] u,
                           output bit has_digit, output logic [DIGIT_W-1:0] digit);
    logic [LIMB_W-1:0]   limb;
    logic [IDX_W-1:0]    idx;
    logic [2*LIMB_W-1:0] prod_lo;
    logic [2*LIMB_W-1:0] prod_hi;
    logic [DIGIT_W-1:0]  sum;
    int d;
    has_digit = 1'b0;
    digit = '0;
    sum = '0;
    limb = w[LIMB_LSB +: LIMB_W];
    idx = w[IDX_LSB +: IDX_W];
    if (u[OP_BIT] == OP_LOAD) begin
      if (idx < TAPS) coeffs[idx] = limb;
    end else begin
      if (u[FIRST_BIT]) begin
        for (d = 0; d <= TAPS; d++) window[d] = '0;
        depth = 0;
      end
      for (d = TAPS; d > 0; d--) window[d] = window[d-1];
      window[0] = limb;
      if (depth < TAPS) depth++;
      if (depth == TAPS) begin
        // low half of a[p-t]*b[t] plus high half of a[p-1-t]*b[t]
        for (d = 0; d < TAPS; d++) begin
          prod_lo = {{LIMB_W{1'b0}}, window[d]} * {{LIMB_W{1'b0}}, coeffs[d]};
          prod_hi = {{LIMB_W{1'b0}}, window[d+1]} * {{LIMB_W{1'b0}}, coeffs[d]};
          sum = sum + DIGIT_W'(prod_lo[LIMB_W-1:0])
                    + DIGIT_W'(prod_hi[2*LIMB_W-1:LIMB_W]);
        end
        has_digit = 1'b1;
        digit = sum;
      end
    end
  endtask

  // scoreboard: output check first, then the word accepted at the same edge
  always @(posedge clk) begin
    bit                 has_digit;
    logic [DIGIT_W-1:0] digit;
    logic [DIGIT_W-1:0] want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (digits_due.size() == 0) begin
          report_mismatch("digit with none pending:", m_tdata[DIGIT_W-1:0], '0);
        end else begin
          want = digits_due.pop_front();
          if (m_tdata[DIGIT_W-1:0] !== want)
            report_mismatch("raw_digit:", m_tdata[DIGIT_W-1:0], want);
        end
      end
      if (s_tvalid && s_tready) begin
        take_word(s_tdata, s_tuser, has_digit, digit);
        if (has_digit) digits_due.push_back(cur_has_exp ? cur_exp : digit);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("radix52_middle_product_unit: mismatch");
    $finish;
  end

  task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [LIMB_W-1:0] limb, input logic first,
                           input bit has_exp, input logic [DIGIT_W-1:0] exp_digit);
    logic [S_DATA_W-1:0] w;
    logic [S_USER_W-1:0] u;
    w = '0;
    u = '0;
    u[OP_BIT] = op;
    w[IDX_LSB +: IDX_W] = idx;
    w[LIMB_LSB +: LIMB_W] = limb;
    u[FIRST_BIT] = first;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= u;
    cur_has_exp <= has_exp;
    cur_exp <= exp_digit;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_digits();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LIMB_W-1:0] rand_limb();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(7))
      0: return '0;
      1: return LIMB_MAX;
      2: return LIMB_W'(1) << $urandom_range(LIMB_W-1);
      default: return r[LIMB_W-1:0];
    endcase
  endfunction

  task automatic set_row(input int i, input logic op, input logic [IDX_W-1:0] idx,
                         input logic [LIMB_W-1:0] limb, input logic first,
                         input bit has_exp, input logic [DIGIT_W-1:0] exp_digit);
    dir_rows[i] = '{op, idx, limb, first, has_exp, exp_digit};
  endtask

  task automatic push_vector();
    int n;
    n = $urandom_range(TAPS - 1, 2 * TAPS + 8);
    // mostly a clean restart; sometimes continue the running vector
    send_word(OP_PUSH, IDX_W'($urandom), rand_limb(), ($urandom_range(7) != 0), 1'b0, '0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(19) == 0)
        send_word(OP_LOAD, IDX_W'($urandom), rand_limb(), 1'($urandom), 1'b0, '0);
      send_word(OP_PUSH, IDX_W'($urandom), rand_limb(), ($urandom_range(29) == 0),
                1'b0, '0);
    end
  endtask

  initial begin
    int snd_pct [4];
    int rcv_pct [4];
    int goal;
    snd_pct = '{0, 63, 0, 27};
    rcv_pct = '{0, 0, 63, 27};
    for (int t = 0; t < TAPS; t++) coeffs[t] = '0;
    for (int t = 0; t <= TAPS; t++) window[t] = '0;
    depth = 0;

    // fill a vector right after reset without a first flag; coefficients are zero
    for (int i = 0; i < TAPS - 1; i++) set_row(i, OP_PUSH, '0, LIMB_MAX, 1'b0, 1'b0, '0);
    set_row(15, OP_PUSH, 4'd15, LIMB_MAX, 1'b0, 1'b1, '0);
    // load ignores first; outer taps at max against an all-ones window
    set_row(16, OP_LOAD, 4'd0,  LIMB_MAX, 1'b1, 1'b0, '0);
    set_row(17, OP_LOAD, 4'd15, LIMB_MAX, 1'b0, 1'b0, '0);
    set_row(18, OP_PUSH, 4'd3,  LIMB_MAX, 1'b0, 1'b1, 57'h1F_FFFF_FFFF_FFFE);
    // restarts while filling
    set_row(19, OP_PUSH, 4'd0,  '0,       1'b1, 1'b0, '0);
    set_row(20, OP_PUSH, 4'd9,  LIMB_MAX, 1'b0, 1'b0, '0);
    set_row(21, OP_LOAD, 4'd7,  52'd1,    1'b0, 1'b0, '0);
    set_row(22, OP_PUSH, 4'd6,  52'd1,    1'b1, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].limb, dir_rows[i].first,
                dir_rows[i].has_exp, dir_rows[i].exp_digit);
    drain_digits();

    for (int ph = 0; ph < 4; ph++) begin
      snd_idle_pct = snd_pct[ph];
      rcv_stall_pct = rcv_pct[ph];
      goal = words_sent + ITEMS_PER_PHASE;
      if (ph == 2) hold_req = 1'b1;
      while (words_sent < goal) begin
        case ($urandom_range(9))
          0: send_word(1'($urandom), IDX_W'($urandom), rand_limb(), 1'($urandom),
                       1'b0, '0);
          1: for (int t = 0; t < TAPS; t++)
               send_word(OP_LOAD, IDX_W'(t), rand_limb(), 1'($urandom), 1'b0, '0);
          2: send_word(OP_LOAD, IDX_W'($urandom), rand_limb(), 1'($urandom), 1'b0, '0);
          default: push_vector();
        endcase
      end
      drain_digits();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("radix52_middle_product_unit: match");
    end else begin
      $display("radix52_middle_product_unit: mismatch");
    end
    $finish;
  end

endmodule
